FILE: hdl/ixhq_pkg.sv
// Package with shared constants, codes and the heap entry type of the heap queue.
`default_nettype none
package ixhq_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int HANDLES_DEFAULT  = 256;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int HANDLE_W  = 8;
   localparam int COUNT_W   = 9;
   localparam int ENTRY_W   = KEY_W + PAYLOAD_W + HANDLE_W;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_UPDATE = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ABSENT  = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_PRESENT = 2'd3;

   // One heap entry, key in the lowest bits.
   typedef struct packed {
      logic [HANDLE_W-1:0]     hdl;
      logic [PAYLOAD_W-1:0]    pay;
      logic signed [KEY_W-1:0] key;
   } entry_type;

endpackage
`default_nettype wire

FILE: hdl/ixhq_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none
module ixhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: hdl/indexed_binary_heap_queue.sv
// Top level of the indexed binary heap priority queue with its sift sequencer.
// A command first looks up its handle. A failed command goes straight to the result, and removing
// the entry in the last slot ends once that entry is read. Otherwise the entry is sifted up level by
// level while it beats its parent, then down while a child beats it, and is written where it stops.
// Throughput: one item at a time; the next is accepted the cycle after the result is loaded.
// Reset: synchronous; the handle table is then cleared, and no item is accepted until that is done.
`default_nettype none
module indexed_binary_heap_queue #(
   parameter int CAPACITY = ixhq_pkg::CAPACITY_DEFAULT,
   parameter int HANDLES  = ixhq_pkg::HANDLES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_wdata,    // max_mode
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,    // key_in[31:0], payload_in[63:32], handle_in[71:64]
   input  wire logic [1:0]  req_tuser,    // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,    // key_out, payload_out, handle_out, entry_count, 0
   output logic [1:0]       rsp_tuser     // status
);

   // Slots run from 1 to CAPACITY; slot value 0 in the handle table means absent.
   localparam int SW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int HW = $clog2(HANDLES);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOOKUP, S_UPD_RD, S_REM_RD, S_REM_LAST,
      S_UP, S_UP_CMP, S_DOWN, S_DN_L, S_DN_R, S_DN_CMP, S_PLACE, S_FINISH
   } state_type;

   state_type           state_ff;
   logic [HW-1:0]       clr_ff;
   logic                max_mode_ff;
   logic [1:0]          cmd_ff;
   logic                h_ok_ff;
   logic [SW-1:0]       count_ff;
   logic [SW-1:0]       i_ff;
   logic [SW-1:0]       s_ff;
   logic [SW:0]         c_ff;
   ixhq_pkg::entry_type cur_ff;     // the entry being sifted into the hole
   ixhq_pkg::entry_type ch_ff;      // the chosen child while sifting down
   logic [1:0]          status_ff;
   ixhq_pkg::entry_type out_ff;
   logic                rsp_valid_ff;

   // Heap store and handle table ports.
   logic                heap_we;
   logic [AW-1:0]       heap_waddr;
   logic [AW-1:0]       heap_raddr;
   ixhq_pkg::entry_type heap_wdata;
   logic [ixhq_pkg::ENTRY_W-1:0] heap_rbits;
   ixhq_pkg::entry_type heap_rd;
   logic                slot_we;
   logic [HW-1:0]       slot_waddr;
   logic [SW-1:0]       slot_wdata;
   logic [HW-1:0]       slot_raddr;
   logic [SW-1:0]       slot_rd;

   assign heap_rd = ixhq_pkg::entry_type'(heap_rbits);

   ixhq_ram #(.WIDTH(ixhq_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_heap (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_addr (heap_raddr),
      .rd_data (heap_rbits)
   );

   ixhq_ram #(.WIDTH(SW), .DEPTH(HANDLES)) u_slots (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rd)
   );

   // Converts a slot number (1..CAPACITY) to a RAM address.
   function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] slot);
      logic [SW-1:0] tmp;
      tmp = slot - SW'(1);
      return tmp[AW-1:0];
   endfunction

   // Converts a stored handle to a handle table index.
   function automatic logic [HW-1:0] hdl_idx(input logic [ixhq_pkg::HANDLE_W-1:0] h);
      logic [31:0] wide;
      wide = 32'(h);
      return wide[HW-1:0];
   endfunction

   logic [ixhq_pkg::HANDLE_W-1:0] req_handle;
   logic                          req_h_ok;
   assign req_handle = req_tdata[71:64];
   assign req_h_ok   = 32'(req_handle) < HANDLES;
   assign slot_raddr = hdl_idx(req_handle);

   // Effective slot of the requested handle; out-of-range handles and slots count as absent.
   logic [SW-1:0] s_eff;
   assign s_eff = (!h_ok_ff || slot_rd == '0 || slot_rd > count_ff) ? '0 : slot_rd;

   logic [SW:0] two_i;
   logic [SW:0] two_i1;
   logic [SW:0] count_x;
   assign two_i   = {i_ff, 1'b0};
   assign two_i1  = {i_ff, 1'b1};
   assign count_x = {1'b0, count_ff};

   logic [SW-1:0] parent;
   assign parent = i_ff >> 1;

   // The one shared comparator: true when key a must sit strictly closer to the root.
   logic signed [31:0] cmp_a;
   logic signed [31:0] cmp_b;
   logic               better;

   always_comb begin
      case (state_ff)
         S_UP_CMP: begin
            cmp_a = cur_ff.key;
            cmp_b = heap_rd.key;
         end
         S_DN_R: begin
            cmp_a = heap_rd.key;
            cmp_b = ch_ff.key;
         end
         default: begin
            cmp_a = ch_ff.key;
            cmp_b = cur_ff.key;
         end
      endcase
      better = max_mode_ff ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
   end

   // Memory port control per sequencer step.
   always_comb begin
      heap_we    = 1'b0;
      heap_waddr = slot_addr(i_ff);
      heap_wdata = cur_ff;
      heap_raddr = slot_addr(i_ff);
      slot_we    = 1'b0;
      slot_waddr = hdl_idx(cur_ff.hdl);
      slot_wdata = i_ff;
      unique case (state_ff)
         S_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = '0;
         end
         S_LOOKUP: begin
            heap_raddr = (cmd_ff == ixhq_pkg::CMD_POP) ? slot_addr(SW'(1)) : slot_addr(s_eff);
         end
         S_REM_RD: begin
            // The removed handle leaves the table; the last entry is fetched next.
            slot_we    = 1'b1;
            slot_waddr = hdl_idx(heap_rd.hdl);
            slot_wdata = '0;
            heap_raddr = slot_addr(count_ff);
         end
         S_UP: begin
            heap_raddr = slot_addr(parent);
         end
         S_UP_CMP: begin
            if (better) begin
               heap_we    = 1'b1;
               heap_wdata = heap_rd;
               slot_we    = 1'b1;
               slot_waddr = hdl_idx(heap_rd.hdl);
            end
         end
         S_DOWN: begin
            heap_raddr = slot_addr(two_i[SW-1:0]);
         end
         S_DN_L: begin
            heap_raddr = slot_addr(two_i1[SW-1:0]);
         end
         S_DN_CMP: begin
            if (better) begin
               heap_we    = 1'b1;
               heap_wdata = ch_ff;
               slot_we    = 1'b1;
               slot_waddr = hdl_idx(ch_ff.hdl);
            end
         end
         S_PLACE: begin
            heap_we = 1'b1;
            slot_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   // The finished result moves into the output register once that register is free.
   logic rsp_load;
   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         max_mode_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            max_mode_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + HW'(1);
               if (32'(clr_ff) == HANDLES - 1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff     <= req_tuser;
                  h_ok_ff    <= req_h_ok;
                  cur_ff.key <= req_tdata[31:0];
                  cur_ff.pay <= req_tdata[63:32];
                  cur_ff.hdl <= req_handle;
                  status_ff  <= ixhq_pkg::STATUS_OK;
                  out_ff     <= '0;
                  state_ff   <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               case (cmd_ff)
                  ixhq_pkg::CMD_INSERT: begin
                     if (!h_ok_ff) begin
                        status_ff <= ixhq_pkg::STATUS_ABSENT;
                        state_ff  <= S_FINISH;
                     end else if (s_eff != '0) begin
                        status_ff <= ixhq_pkg::STATUS_PRESENT;
                        state_ff  <= S_FINISH;
                     end else if (32'(count_ff) >= CAPACITY) begin
                        status_ff <= ixhq_pkg::STATUS_FULL;
                        state_ff  <= S_FINISH;
                     end else begin
                        count_ff <= count_ff + SW'(1);
                        i_ff     <= count_ff + SW'(1);
                        state_ff <= S_UP;
                     end
                  end
                  ixhq_pkg::CMD_POP: begin
                     if (count_ff == '0) begin
                        status_ff <= ixhq_pkg::STATUS_ABSENT;
                        state_ff  <= S_FINISH;
                     end else begin
                        s_ff     <= SW'(1);
                        state_ff <= S_REM_RD;
                     end
                  end
                  default: begin
                     if (s_eff == '0) begin
                        status_ff <= ixhq_pkg::STATUS_ABSENT;
                        state_ff  <= S_FINISH;
                     end else begin
                        s_ff     <= s_eff;
                        state_ff <= (cmd_ff == ixhq_pkg::CMD_REMOVE) ? S_REM_RD : S_UPD_RD;
                     end
                  end
               endcase
            end
            S_UPD_RD: begin
               cur_ff.pay <= heap_rd.pay;
               cur_ff.hdl <= heap_rd.hdl;
               i_ff       <= s_ff;
               state_ff   <= S_UP;
            end
            S_REM_RD: begin
               out_ff   <= heap_rd;
               count_ff <= count_ff - SW'(1);
               state_ff <= (s_ff == count_ff) ? S_FINISH : S_REM_LAST;
            end
            S_REM_LAST: begin
               cur_ff   <= heap_rd;
               i_ff     <= s_ff;
               state_ff <= S_UP;
            end
            S_UP: begin
               state_ff <= (i_ff > SW'(1)) ? S_UP_CMP : S_DOWN;
            end
            S_UP_CMP: begin
               if (better) begin
                  i_ff     <= parent;
                  state_ff <= S_UP;
               end else begin
                  state_ff <= S_DOWN;
               end
            end
            S_DOWN: begin
               state_ff <= (two_i <= count_x) ? S_DN_L : S_PLACE;
            end
            S_DN_L: begin
               ch_ff    <= heap_rd;
               c_ff     <= two_i;
               state_ff <= (two_i1 <= count_x) ? S_DN_R : S_DN_CMP;
            end
            S_DN_R: begin
               // Equal children keep the left one.
               if (better) begin
                  ch_ff <= heap_rd;
                  c_ff  <= two_i1;
               end
               state_ff <= S_DN_CMP;
            end
            S_DN_CMP: begin
               if (better) begin
                  i_ff     <= c_ff[SW-1:0];
                  state_ff <= S_DOWN;
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               // Waits here while an earlier result has not been taken.
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Result register, loaded once the sequence ends.
   logic [1:0]  rsp_status_ff;
   logic [71:0] rsp_entry_ff;
   logic [8:0]  rsp_count_ff;
   logic [31:0] count_wide;
   assign count_wide = 32'(count_ff);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_entry_ff  <= out_ff;
         rsp_count_ff  <= count_wide[8:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_entry_ff};

endmodule
`default_nettype wire
